>>> rtl/fwsm_pkg.sv
`default_nettype none

package fwsm_pkg;

  // field widths
  localparam int DEMAND_W = 16;
  localparam int PULSE_W  = 12;
  localparam int CFG_W    = 12;
  localparam int IDX_W    = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_CROW_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_PULSE_MIN      = 2'd1;
  localparam logic [IDX_W-1:0] REG_PULSE_MAX      = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] CROW_THRESHOLD_RST = 12'd1750;
  localparam logic [CFG_W-1:0] PULSE_MIN_RST      = 12'd1000;
  localparam logic [CFG_W-1:0] PULSE_MAX_RST      = 12'd2000;

  // pulse offset: (x + 3) * 500 in thousandths of a unit
  localparam int PULSE_OFFSET_MILLI = 3000;

endpackage

`default_nettype wire

>>> rtl/fwsm_pulse.sv
`default_nettype none

module fwsm_pulse
  import fwsm_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  parameter int SUM_W     = 37
) (
  input  wire logic signed [SUM_W-1:0]   chan_sum,
  input  wire logic        [PULSE_W-1:0] pulse_min,
  input  wire logic        [PULSE_W-1:0] pulse_max,
  output logic             [PULSE_W-1:0] pulse
);

  localparam int Q_W = SUM_W - FRAC_BITS - 1;

  localparam logic signed [SUM_W-1:0] OFFSET =
    SUM_W'(PULSE_OFFSET_MILLI) <<< FRAC_BITS;

  logic signed [SUM_W-1:0] shifted;
  logic        [Q_W-1:0]   quot;

  // offset by three units, then divide by 2 * 2^F (truncating)
  assign shifted = chan_sum + OFFSET;
  assign quot    = Q_W'(shifted >>> (FRAC_BITS + 1));

  // floor test first, then ceiling
  always_comb begin
    if (shifted[SUM_W-1]) begin
      pulse = pulse_min;
    end else if (quot < Q_W'(pulse_min)) begin
      pulse = pulse_min;
    end else if (quot > Q_W'(pulse_max)) begin
      pulse = pulse_max;
    end else begin
      pulse = quot[PULSE_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/flying_wing_servo_mixer.sv
`default_nettype none
// Pipeline: each input transfer passes in order through the input register, operand stage,
// mixing stage and pulse output register, which presents the result on m_tdata.
// Throughput: one item per clock; each stage holds while the stage after it is full and stalled.
// Reset (rst, synchronous): empties the pipeline and loads the configuration registers with
// crow_threshold 1750, pulse_min 1000, pulse_max 2000.

module flying_wing_servo_mixer
  import fwsm_pkg::*;
#(
  parameter int DEMAND_FRAC_BITS = 14
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // input stream
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // manual flag, crow_switch_pulse, roll_demand, pitch_demand, yaw_demand,
  // thrust_demand, flap_demand, zero pad
  input  wire logic [95:0]      s_tdata,
  // output stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // port_vtail_pulse, throttle_pulse, stbd_outer_aileron_pulse,
  // stbd_inner_aileron_pulse, port_inner_aileron_pulse,
  // port_outer_aileron_pulse, stbd_vtail_pulse, zero pad
  output logic [87:0]           m_tdata,
  // configuration writes
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int VAL_W = ((DEMAND_FRAC_BITS > 17) ? DEMAND_FRAC_BITS : 17) + 3;
  localparam int SUM_W = VAL_W + 14;
  localparam logic signed [VAL_W-1:0] ONE = VAL_W'(64'sd1 <<< DEMAND_FRAC_BITS);

  // configuration registers
  logic [CFG_W-1:0] crow_threshold;
  logic [CFG_W-1:0] pulse_min;
  logic [CFG_W-1:0] pulse_max;

  // stage valids and enables
  logic in_v, a_v, b_v;
  logic in_en, a_en, b_en, out_en;

  // input register
  logic                       manual_flag;
  logic [PULSE_W-1:0]         crow_switch_pulse;
  logic signed [DEMAND_W-1:0] roll_demand, pitch_demand, yaw_demand;
  logic signed [DEMAND_W-1:0] thrust_demand, flap_demand;

  // operand stage
  logic signed [VAL_W-1:0]    r_next, crow_next, flap_next, crow2_next, thr_next;
  logic                       crow_sel, brake_on;
  logic signed [VAL_W-1:0]    r_a, crow_a, flap_a, crow2_a, thr_a;
  logic signed [DEMAND_W-1:0] p_a, y_a;
  logic                       pos_a, up_a;

  // mixing stage
  logic signed [SUM_W-1:0] r_x, p_x, y_x, crow_x, flap_x, crow2_x;
  logic signed [SUM_W-1:0] pi_next, si_next, po_next, so_next, pv_next, sv_next, thr_x;
  logic signed [SUM_W-1:0] pi_b, si_b, po_b, so_b, pv_b, sv_b, thr_b;

  // pulse conversion
  logic signed [SUM_W-1:0] chan_sum [7];
  logic [PULSE_W-1:0]      pulse_next [7];
  logic [PULSE_W-1:0]      pulse [7];

  assign out_en   = !m_tvalid || m_tready;
  assign b_en     = !b_v || out_en;
  assign a_en     = !a_v || b_en;
  assign in_en    = !in_v || a_en;
  assign s_tready = in_en;

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v           <= 1'b0;
      a_v            <= 1'b0;
      b_v            <= 1'b0;
      m_tvalid       <= 1'b0;
      crow_threshold <= CROW_THRESHOLD_RST;
      pulse_min      <= PULSE_MIN_RST;
      pulse_max      <= PULSE_MAX_RST;
    end else begin
      if (in_en)  in_v     <= s_tvalid;
      if (a_en)   a_v      <= in_v;
      if (b_en)   b_v      <= a_v;
      if (out_en) m_tvalid <= b_v;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CROW_THRESHOLD: crow_threshold <= cfg_data;
          REG_PULSE_MIN:      pulse_min      <= cfg_data;
          REG_PULSE_MAX:      pulse_max      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // input register load
  always_ff @(posedge clk) begin
    if (in_en) begin
      manual_flag       <= s_tdata[0];
      crow_switch_pulse <= s_tdata[12:1];
      roll_demand       <= s_tdata[28:13];
      pitch_demand      <= s_tdata[44:29];
      yaw_demand        <= s_tdata[60:45];
      thrust_demand     <= s_tdata[76:61];
      flap_demand       <= s_tdata[92:77];
    end
  end

  // operands: negated roll, crow terms, flap position, throttle base
  always_comb begin
    crow_sel   = manual_flag && (crow_switch_pulse > crow_threshold);
    brake_on   = crow_sel && thrust_demand[DEMAND_W-1];
    r_next     = -VAL_W'(roll_demand);
    crow_next  = brake_on ? -(VAL_W'(thrust_demand) <<< 1) : '0;
    if (!crow_sel) begin
      flap_next = -VAL_W'(flap_demand);
    end else if (brake_on) begin
      flap_next = ONE - crow_next;
    end else begin
      flap_next = ONE;
    end
    crow2_next = (crow_next <<< 1) - ONE;
    thr_next   = crow_sel ? (VAL_W'(thrust_demand) <<< 1) - ONE : VAL_W'(thrust_demand);
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      r_a     <= r_next;
      p_a     <= pitch_demand;
      y_a     <= yaw_demand;
      crow_a  <= crow_next;
      flap_a  <= flap_next;
      crow2_a <= crow2_next;
      thr_a   <= thr_next;
      pos_a   <= (r_next > 0);
      up_a    <= flap_next[VAL_W-1];
    end
  end

  // channel mixing in thousandths times 2^F
  always_comb begin
    r_x     = SUM_W'(r_a);
    p_x     = SUM_W'(p_a);
    y_x     = SUM_W'(y_a);
    crow_x  = SUM_W'(crow_a);
    flap_x  = SUM_W'(flap_a);
    crow2_x = SUM_W'(crow2_a);

    pi_next = (pos_a ? r_x * SUM_W'(525) : r_x * SUM_W'(350))
            - (up_a ? flap_x * SUM_W'(70) : flap_x * SUM_W'(210))
            - crow2_x * SUM_W'(250);
    si_next = (pos_a ? r_x * SUM_W'(350) : r_x * SUM_W'(525))
            + (up_a ? flap_x * SUM_W'(70) : flap_x * SUM_W'(210))
            + crow2_x * SUM_W'(250);
    po_next = (pos_a ? r_x * SUM_W'(750) : r_x * SUM_W'(500))
            - (up_a ? flap_x * SUM_W'(100) : flap_x * SUM_W'(300))
            + crow2_x * SUM_W'(150);
    so_next = (pos_a ? r_x * SUM_W'(500) : r_x * SUM_W'(750))
            + (up_a ? flap_x * SUM_W'(100) : flap_x * SUM_W'(300))
            - crow2_x * SUM_W'(150);
    pv_next = (p_x + y_x) * SUM_W'(500) - r_x * SUM_W'(300)
            + (up_a ? flap_x * SUM_W'(10) : flap_x * SUM_W'(30))
            + crow_x * SUM_W'(100);
    sv_next = (y_x - p_x) * SUM_W'(500) - r_x * SUM_W'(300)
            - (up_a ? flap_x * SUM_W'(10) : flap_x * SUM_W'(30))
            - crow_x * SUM_W'(100);
    thr_x   = SUM_W'(thr_a) * SUM_W'(1000);
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      pi_b  <= pi_next;
      si_b  <= si_next;
      po_b  <= po_next;
      so_b  <= so_next;
      pv_b  <= pv_next;
      sv_b  <= sv_next;
      thr_b <= thr_x;
    end
  end

  // pulse conversion and saturation, in output order
  assign chan_sum[0] = pv_b;
  assign chan_sum[1] = thr_b;
  assign chan_sum[2] = so_b;
  assign chan_sum[3] = si_b;
  assign chan_sum[4] = pi_b;
  assign chan_sum[5] = po_b;
  assign chan_sum[6] = sv_b;

  for (genvar ch = 0; ch < 7; ch++) begin : g_pulse
    fwsm_pulse #(
      .FRAC_BITS (DEMAND_FRAC_BITS),
      .SUM_W     (SUM_W)
    ) u_pulse (
      .chan_sum  (chan_sum[ch]),
      .pulse_min (pulse_min),
      .pulse_max (pulse_max),
      .pulse     (pulse_next[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      for (int i = 0; i < 7; i++) begin
        pulse[i] <= pulse_next[i];
      end
    end
  end

  assign m_tdata = {4'b0000, pulse[6], pulse[5], pulse[4], pulse[3],
                    pulse[2], pulse[1], pulse[0]};

endmodule

`default_nettype wire
